FILE: src/des_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg: DES constants and round functions
// Permutation tables, S-boxes, key schedule helpers and the round function.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned ROUNDS = 16;

  typedef logic [31:0] half_t;
  typedef logic [27:0] kh_t;
  typedef logic [47:0] rkey_t;

  typedef logic [5:0] tab48_t [48];
  typedef logic [5:0] tab32_t [32];
  typedef logic [5:0] tab56_t [56];

  localparam tab48_t TAB_E = '{
    6'd32, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
    6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

  localparam tab32_t TAB_P = '{
    6'd16, 6'd7, 6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17, 6'd1, 6'd15, 6'd23,
    6'd26, 6'd5, 6'd18, 6'd31, 6'd10, 6'd2, 6'd8, 6'd24, 6'd14, 6'd32, 6'd27,
    6'd3, 6'd9, 6'd19, 6'd13, 6'd30, 6'd6, 6'd22, 6'd11, 6'd4, 6'd25};

  localparam tab56_t TAB_PC1 = '{
    6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9, 6'd1, 6'd58, 6'd50, 6'd42, 6'd34,
    6'd26, 6'd18, 6'd10, 6'd2, 6'd59, 6'd51, 6'd43, 6'd35, 6'd27, 6'd19, 6'd11, 6'd3,
    6'd60, 6'd52, 6'd44, 6'd36, 6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd23, 6'd15, 6'd7,
    6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22, 6'd14, 6'd6, 6'd61, 6'd53, 6'd45, 6'd37,
    6'd29, 6'd21, 6'd13, 6'd5, 6'd28, 6'd20, 6'd12, 6'd4};

  localparam tab48_t TAB_PC2 = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1, 6'd5, 6'd3, 6'd28, 6'd15, 6'd6, 6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4, 6'd26, 6'd8, 6'd16, 6'd7, 6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

  // rotation amount per round: single step in rounds 1, 2, 9, 16
  localparam logic [15:0] ROT_ONE = 16'b1100_0000_1000_0001;

  typedef logic [3:0] sbox_t [8][64];
  localparam sbox_t SBOX = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // PC-1: 64-bit key to C0||D0
  function automatic logic [55:0] pc1(input logic [63:0] k);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = k[64 - int'(TAB_PC1[i])];
    return r;
  endfunction

  // PC-2: C||D to 48-bit round key
  function automatic rkey_t pc2(input kh_t c, input kh_t d);
    logic [55:0] cd;
    rkey_t r;
    cd = {c, d};
    for (int i = 0; i < 48; i++) r[47-i] = cd[56 - int'(TAB_PC2[i])];
    return r;
  endfunction

  // round rotation of one key half
  function automatic kh_t rot(input kh_t h, input logic one);
    return one ? {h[26:0], h[27]} : {h[25:0], h[27:26]};
  endfunction

  // f(R, K): expansion, key mix, S-boxes, P
  function automatic half_t feistel(input half_t r, input rkey_t k);
    rkey_t x;
    half_t o;
    half_t p;
    logic [5:0] b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TAB_E[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      o[31-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32 - int'(TAB_P[i])];
    return p;
  endfunction

endpackage

FILE: src/des_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_round: one registered Feistel round
// Applies f with the given round key, swaps halves, registers with valid.
// ----------------------------------------------------------------------------
module des_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  des_pkg::half_t    in_l,
  input  des_pkg::half_t    in_r,
  input  des_pkg::rkey_t    rkey,
  output logic              out_vld,
  output des_pkg::half_t    out_l,
  output des_pkg::half_t    out_r
);

  logic           vld_r;
  des_pkg::half_t l_r;
  des_pkg::half_t r_r;

  // valid travels with data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // round data
  always_ff @(posedge clk) begin
    if (in_vld) begin
      l_r <= in_r;
      r_r <= in_l ^ des_pkg::feistel(in_r, rkey);
    end
  end

  assign out_vld = vld_r;
  assign out_l   = l_r;
  assign out_r   = r_r;

endmodule

FILE: src/des_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_block_encrypt: pipelined DES encryption, no IP / FP
// Sixteen registered rounds; round keys held in registers from the key write.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  input   | start, busy, in_plaintext_block        | start && !busy
//  result  | out_strobe, out_cipher_block           | one-cycle strobe
//  config  | cfg_valid, cfg_ready, cfg_cipher_key   | valid && ready
//
// One item per cycle; the result passes the input register plus sixteen round
// stages. busy is always low: the result strobe cannot be held off, so nothing
// stalls. Round keys are recomputed into registers the cycle after a key
// write. Synchronous active-low reset clears valids and key.
module des_block_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_plaintext_block,
  output logic        out_strobe,
  output logic [63:0] out_cipher_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_cipher_key
);

  localparam int unsigned NR = des_pkg::ROUNDS;

  des_pkg::rkey_t rkey_r [NR];
  logic           vld [NR+1];
  des_pkg::half_t lh  [NR+1];
  des_pkg::half_t rh  [NR+1];
  logic           in_vld_r;
  des_pkg::half_t in_l_r;
  des_pkg::half_t in_r_r;
  des_pkg::kh_t   c_s [NR+1];
  des_pkg::kh_t   d_s [NR+1];
  logic [55:0]    cd0;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // key schedule, registered per round on key write (reset key is zero)
  assign cd0    = des_pkg::pc1(cfg_cipher_key);
  assign c_s[0] = cd0[55:28];
  assign d_s[0] = cd0[27:0];
  for (genvar g = 0; g < NR; g++) begin : g_ks
    assign c_s[g+1] = des_pkg::rot(c_s[g], des_pkg::ROT_ONE[15-g]);
    assign d_s[g+1] = des_pkg::rot(d_s[g], des_pkg::ROT_ONE[15-g]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rkey_r[g] <= '0;
      end else if (cfg_valid) begin
        rkey_r[g] <= des_pkg::pc2(c_s[g+1], d_s[g+1]);
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      in_l_r <= in_plaintext_block[63:32];
      in_r_r <= in_plaintext_block[31:0];
    end
  end

  assign vld[0] = in_vld_r;
  assign lh[0]  = in_l_r;
  assign rh[0]  = in_r_r;

  // round stages
  for (genvar g = 0; g < NR; g++) begin : g_rnd
    des_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[g]),
      .in_l    (lh[g]),
      .in_r    (rh[g]),
      .rkey    (rkey_r[g]),
      .out_vld (vld[g+1]),
      .out_l   (lh[g+1]),
      .out_r   (rh[g+1])
    );
  end

  assign out_strobe       = vld[NR];
  assign out_cipher_block = {rh[NR], lh[NR]};

  // checks
  a_strobe_lat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, 17) && $past(rst_n, 17) |-> out_strobe)
    else $error("result strobe missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(vld[NR-1]))
    else $error("unexpected strobe");
  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    vld[0] |=> vld[1])
    else $error("valid lost in first round");

endmodule
